/* rtl/wcos_pkg.sv */
// ----------------------------------------------------------------------------
// Water orientation cosines: shared types and constants
// Field widths, payload structs, register indexes and the per-stage step
// count of the pipelined dividers and square root.
// ----------------------------------------------------------------------------
`default_nettype none

package wcos_pkg;

    localparam int CoordW   = 32;
    localparam int BoxW     = 31;
    localparam int CosW     = 16;
    localparam int IdxW     = 16;
    localparam int DiffW    = CoordW + 1;
    localparam int VecW     = CoordW + 2;
    localparam int Axes     = 3;
    localparam int FoldLanes = 2 * Axes;
    localparam int CosLanes = 3;
    localparam int CfgAddrW = 3;
    localparam int CosOneInt = 16384;
    localparam int StepsPerStageDefault = 2;

    typedef enum logic [CfgAddrW-1:0] {
        REG_BOX_X     = 3'd0,
        REG_BOX_Y     = 3'd1,
        REG_BOX_Z     = 3'd2,
        REG_NORMAL_X  = 3'd3,
        REG_NORMAL_Y  = 3'd4,
        REG_NORMAL_Z  = 3'd5,
        REG_NO_Z_WRAP = 3'd6
    } cfg_reg_t;

    typedef logic signed [DiffW-1:0] diff_t;
    typedef logic [BoxW-1:0]         box_t;
    typedef logic signed [CosW-1:0]  cos_t;

    typedef struct packed {
        logic signed [CoordW-1:0] o_x;
        logic signed [CoordW-1:0] o_y;
        logic signed [CoordW-1:0] o_z;
        logic signed [CoordW-1:0] h1_x;
        logic signed [CoordW-1:0] h1_y;
        logic signed [CoordW-1:0] h1_z;
        logic signed [CoordW-1:0] h2_x;
        logic signed [CoordW-1:0] h2_y;
        logic signed [CoordW-1:0] h2_z;
        logic [IdxW-1:0]          water_index;
        logic                     last_in_frame;
    } water_in_t;

    typedef struct packed {
        logic [IdxW-1:0]          molecule_index;
        cos_t                     cos_oh1;
        cos_t                     cos_oh2;
        cos_t                     cos_dipole;
        logic signed [CoordW-1:0] oxygen_height;
        logic                     frame_end;
    } water_out_t;

    // Fields that ride alongside the arithmetic untouched
    typedef struct packed {
        logic [IdxW-1:0]          index;
        logic                     last;
        logic signed [CoordW-1:0] height;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/wcos_fold.sv */
// ----------------------------------------------------------------------------
// Minimum-image fold
// Six displacement lanes folded by d - round(d/L)*L. The remainder of a
// pipelined restoring division of 2|d|+L by 2L gives the folded value.
// ----------------------------------------------------------------------------
`default_nettype none

module wcos_fold #(
    parameter int STEPS_PER_STAGE = wcos_pkg::StepsPerStageDefault
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wcos_pkg::tag_t        in_tag,
    input  wcos_pkg::diff_t       in_d    [wcos_pkg::FoldLanes],
    input  wcos_pkg::box_t        in_len  [wcos_pkg::FoldLanes],
    input  wire logic             in_wrap [wcos_pkg::FoldLanes],
    output logic                  out_valid,
    output wcos_pkg::tag_t        out_tag,
    output wcos_pkg::diff_t       out_d   [wcos_pkg::FoldLanes]
);
    import wcos_pkg::*;

    localparam int NumW      = DiffW + 1;
    localparam int DenW      = BoxW + 1;
    localparam int NumStages = (NumW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic            valid_reg [NumStages+1];
    tag_t            tag_reg   [NumStages+1];
    logic [NumW-1:0] num_reg   [NumStages+1][FoldLanes];
    logic [DenW-1:0] rem_reg   [NumStages+1][FoldLanes];
    logic            neg_reg   [NumStages+1][FoldLanes];
    diff_t           keep_reg  [NumStages+1][FoldLanes];

    logic [NumW-1:0] num_next  [NumStages][FoldLanes];
    logic [DenW-1:0] rem_next  [NumStages][FoldLanes];
    logic [NumW-1:0] num_load  [FoldLanes];

    logic            out_valid_reg;
    tag_t            out_tag_reg;
    diff_t           out_d_reg [FoldLanes];
    diff_t           out_d_next [FoldLanes];

    always_comb begin
        logic [DiffW-1:0] mag;
        for (int l = 0; l < FoldLanes; l++) begin
            mag = in_d[l][DiffW-1] ? (~in_d[l] + 1'b1) : in_d[l];
            num_load[l] = {mag, 1'b0} + NumW'(in_len[l]);
        end
    end

    // Restoring division, MSB first; only the remainder is kept
    always_comb begin
        logic [DenW:0]   t;
        logic [DenW-1:0] r;
        logic [NumW-1:0] n;
        logic [DenW-1:0] den;
        for (int s = 0; s < NumStages; s++) begin
            for (int l = 0; l < FoldLanes; l++) begin
                den = {in_len[l], 1'b0};
                r   = rem_reg[s][l];
                n   = num_reg[s][l];
                for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                    if (s * STEPS_PER_STAGE + j < NumW) begin
                        t = {r, n[NumW-1]};
                        n = {n[NumW-2:0], 1'b0};
                        if (t >= {1'b0, den}) begin
                            t = t - {1'b0, den};
                        end
                        r = t[DenW-1:0];
                    end
                end
                rem_next[s][l] = r;
                num_next[s][l] = n;
            end
        end
    end

    // Folded magnitude is (rem - L) / 2, exact
    always_comb begin
        logic signed [DenW:0] diff;
        logic signed [DenW:0] half;
        for (int l = 0; l < FoldLanes; l++) begin
            diff = $signed({1'b0, rem_reg[NumStages][l]}) - $signed({2'b00, in_len[l]});
            half = diff >>> 1;
            if (!in_wrap[l]) begin
                out_d_next[l] = keep_reg[NumStages][l];
            end else if (neg_reg[NumStages][l]) begin
                out_d_next[l] = DiffW'(-half);
            end else begin
                out_d_next[l] = DiffW'(half);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NumStages; s++) begin
                valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int s = 0; s < NumStages; s++) begin
                valid_reg[s+1] <= valid_reg[s];
            end
            out_valid_reg <= valid_reg[NumStages];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < FoldLanes; l++) begin
                num_reg[0][l]  <= num_load[l];
                rem_reg[0][l]  <= '0;
                neg_reg[0][l]  <= in_d[l][DiffW-1];
                keep_reg[0][l] <= in_d[l];
            end
            for (int s = 0; s < NumStages; s++) begin
                tag_reg[s+1] <= tag_reg[s];
                for (int l = 0; l < FoldLanes; l++) begin
                    num_reg[s+1][l]  <= num_next[s][l];
                    rem_reg[s+1][l]  <= rem_next[s][l];
                    neg_reg[s+1][l]  <= neg_reg[s][l];
                    keep_reg[s+1][l] <= keep_reg[s][l];
                end
            end
            out_tag_reg <= tag_reg[NumStages];
            for (int l = 0; l < FoldLanes; l++) begin
                out_d_reg[l] <= out_d_next[l];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_d     = out_d_reg;

endmodule

`default_nettype wire

/* rtl/wcos_cos.sv */
// ----------------------------------------------------------------------------
// Cosine unit
// Forms O-H1, O-H2 and dipole vectors, normalises each to a 30-bit leading
// magnitude, squares and dots with the normal, then a pipelined square root
// and a pipelined rounding divide give the Q2.14 cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module wcos_cos #(
    parameter int STEPS_PER_STAGE = wcos_pkg::StepsPerStageDefault
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wcos_pkg::tag_t        in_tag,
    input  wcos_pkg::diff_t       in_d    [wcos_pkg::FoldLanes],
    input  wcos_pkg::cos_t        normal  [wcos_pkg::Axes],
    output logic                  out_valid,
    output wcos_pkg::tag_t        out_tag,
    output wcos_pkg::cos_t        out_cos [wcos_pkg::CosLanes]
);
    import wcos_pkg::*;

    localparam int LenW     = $clog2(VecW + 1);
    localparam int NormW    = 30;
    localparam int SqW      = 2 * NormW;
    localparam int ProdW    = NormW + 1 + CosW;
    localparam int SumW     = SqW + 2;
    localparam int DotW     = ProdW + 1;
    localparam int MagW     = DotW - 1;
    localparam int RootW    = SumW / 2;
    localparam int RemW     = RootW + 2;
    localparam int SqStages = (RootW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DenW     = RootW + 1;
    localparam int QW       = 20;
    localparam int NW       = MagW + 2;
    localparam int DvStages = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Vector forming
    logic                   a_valid_reg;
    tag_t                   a_tag_reg;
    logic signed [VecW-1:0] a_vec_reg [CosLanes][Axes];

    // Magnitudes
    logic                   b_valid_reg;
    tag_t                   b_tag_reg;
    logic [VecW-1:0]        b_mag_reg [CosLanes][Axes];
    logic                   b_neg_reg [CosLanes][Axes];
    logic [VecW-1:0]        b_or_reg  [CosLanes];

    // Bit length
    logic                   c_valid_reg;
    tag_t                   c_tag_reg;
    logic [VecW-1:0]        c_mag_reg [CosLanes][Axes];
    logic                   c_neg_reg [CosLanes][Axes];
    logic [LenW-1:0]        c_len_reg [CosLanes];
    logic [LenW-1:0]        c_len_next [CosLanes];

    // Normalised
    logic                   d_valid_reg;
    tag_t                   d_tag_reg;
    logic [NormW-1:0]       d_norm_reg [CosLanes][Axes];
    logic                   d_neg_reg  [CosLanes][Axes];
    logic                   d_zero_reg [CosLanes];
    logic [NormW-1:0]       d_norm_next [CosLanes][Axes];

    // Products
    logic                    e_valid_reg;
    tag_t                    e_tag_reg;
    logic [SqW-1:0]          e_sq_reg   [CosLanes][Axes];
    logic signed [ProdW-1:0] e_prod_reg [CosLanes][Axes];
    logic                    e_neg_reg  [CosLanes][Axes];
    logic                    e_zero_reg [CosLanes];

    // Square root pipeline, stage 0 holds the sums
    logic                   s_valid_reg [SqStages+1];
    tag_t                   s_tag_reg   [SqStages+1];
    logic [SumW-1:0]        s_m_reg     [SqStages+1][CosLanes];
    logic [RemW-1:0]        s_rem_reg   [SqStages+1][CosLanes];
    logic [RootW-1:0]       s_res_reg   [SqStages+1][CosLanes];
    logic signed [DotW-1:0] s_dot_reg   [SqStages+1][CosLanes];
    logic                   s_zero_reg  [SqStages+1][CosLanes];
    logic [SumW-1:0]        s_m_next    [SqStages][CosLanes];
    logic [RemW-1:0]        s_rem_next  [SqStages][CosLanes];
    logic [RootW-1:0]       s_res_next  [SqStages][CosLanes];
    logic [SumW-1:0]        sum_m       [CosLanes];
    logic signed [DotW-1:0] sum_dot     [CosLanes];

    // Rounding divide pipeline, stage 0 holds the prepared operands
    logic                   v_valid_reg [DvStages+1];
    tag_t                   v_tag_reg   [DvStages+1];
    logic [DenW-1:0]        v_rem_reg   [DvStages+1][CosLanes];
    logic [QW-1:0]          v_low_reg   [DvStages+1][CosLanes];
    logic [QW-1:0]          v_q_reg     [DvStages+1][CosLanes];
    logic [DenW-1:0]        v_den_reg   [DvStages+1][CosLanes];
    logic                   v_neg_reg   [DvStages+1][CosLanes];
    logic                   v_zero_reg  [DvStages+1][CosLanes];
    logic [DenW-1:0]        v_rem_next  [DvStages][CosLanes];
    logic [QW-1:0]          v_low_next  [DvStages][CosLanes];
    logic [QW-1:0]          v_q_next    [DvStages][CosLanes];
    logic [DenW-1:0]        prep_rem    [CosLanes];
    logic [QW-1:0]          prep_low    [CosLanes];
    logic [DenW-1:0]        prep_den    [CosLanes];

    logic                   out_valid_reg;
    tag_t                   out_tag_reg;
    cos_t                   out_cos_reg  [CosLanes];
    cos_t                   out_cos_next [CosLanes];

    // Bit length of the largest magnitude equals that of the OR of all three
    always_comb begin
        for (int l = 0; l < CosLanes; l++) begin
            c_len_next[l] = '0;
            for (int i = 0; i < VecW; i++) begin
                if (b_or_reg[l][i]) begin
                    c_len_next[l] = LenW'(i + 1);
                end
            end
        end
    end

    always_comb begin
        logic [VecW-1:0] sh;
        for (int l = 0; l < CosLanes; l++) begin
            for (int c = 0; c < Axes; c++) begin
                if (c_len_reg[l] > LenW'(NormW)) begin
                    sh = c_mag_reg[l][c] >> (c_len_reg[l] - LenW'(NormW));
                end else begin
                    sh = c_mag_reg[l][c] << (LenW'(NormW) - c_len_reg[l]);
                end
                d_norm_next[l][c] = sh[NormW-1:0];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < CosLanes; l++) begin
            sum_m[l]   = '0;
            sum_dot[l] = '0;
            for (int c = 0; c < Axes; c++) begin
                sum_m[l] = sum_m[l] + SumW'(e_sq_reg[l][c]);
                if (e_neg_reg[l][c]) begin
                    sum_dot[l] = sum_dot[l] - DotW'(e_prod_reg[l][c]);
                end else begin
                    sum_dot[l] = sum_dot[l] + DotW'(e_prod_reg[l][c]);
                end
            end
        end
    end

    // Digit-by-digit integer square root, two bits of m per result bit
    always_comb begin
        logic [RemW+1:0]  t;
        logic [RemW+1:0]  trial;
        logic [RemW-1:0]  r;
        logic [RootW-1:0] q;
        logic [SumW-1:0]  m;
        for (int s = 0; s < SqStages; s++) begin
            for (int l = 0; l < CosLanes; l++) begin
                r = s_rem_reg[s][l];
                q = s_res_reg[s][l];
                m = s_m_reg[s][l];
                for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                    if (s * STEPS_PER_STAGE + j < RootW) begin
                        t     = {r, m[SumW-1 -: 2]};
                        m     = {m[SumW-3:0], 2'b00};
                        trial = (RemW+2)'({q, 2'b01});
                        if (t >= trial) begin
                            t = t - trial;
                            q = {q[RootW-2:0], 1'b1};
                        end else begin
                            q = {q[RootW-2:0], 1'b0};
                        end
                        r = t[RemW-1:0];
                    end
                end
                s_rem_next[s][l] = r;
                s_res_next[s][l] = q;
                s_m_next[s][l]   = m;
            end
        end
    end

    // Operands of round(|dot| / r): (2|dot| + r) / 2r
    always_comb begin
        logic [DotW-1:0] dmag;
        logic [NW-1:0]   num;
        for (int l = 0; l < CosLanes; l++) begin
            dmag = s_dot_reg[SqStages][l][DotW-1] ? DotW'(-s_dot_reg[SqStages][l])
                                                  : DotW'(s_dot_reg[SqStages][l]);
            num = {dmag[MagW-1:0], 1'b0} + NW'(s_res_reg[SqStages][l]);
            prep_rem[l] = DenW'(num[NW-1:QW]);
            prep_low[l] = num[QW-1:0];
            prep_den[l] = {s_res_reg[SqStages][l], 1'b0};
        end
    end

    always_comb begin
        logic [DenW:0]   t;
        logic [DenW-1:0] r;
        logic [QW-1:0]   lo;
        logic [QW-1:0]   q;
        for (int s = 0; s < DvStages; s++) begin
            for (int l = 0; l < CosLanes; l++) begin
                r  = v_rem_reg[s][l];
                lo = v_low_reg[s][l];
                q  = v_q_reg[s][l];
                for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                    if (s * STEPS_PER_STAGE + j < QW) begin
                        t  = {r, lo[QW-1]};
                        lo = {lo[QW-2:0], 1'b0};
                        if (t >= {1'b0, v_den_reg[s][l]}) begin
                            t = t - {1'b0, v_den_reg[s][l]};
                            q = {q[QW-2:0], 1'b1};
                        end else begin
                            q = {q[QW-2:0], 1'b0};
                        end
                        r = t[DenW-1:0];
                    end
                end
                v_rem_next[s][l] = r;
                v_low_next[s][l] = lo;
                v_q_next[s][l]   = q;
            end
        end
    end

    // Saturate at one, restore the sign, zero for a null vector
    always_comb begin
        logic [CosW-1:0] sat;
        for (int l = 0; l < CosLanes; l++) begin
            if (v_q_reg[DvStages][l] > QW'(CosOneInt)) begin
                sat = CosW'(CosOneInt);
            end else begin
                sat = CosW'(v_q_reg[DvStages][l]);
            end
            if (v_zero_reg[DvStages][l]) begin
                out_cos_next[l] = '0;
            end else if (v_neg_reg[DvStages][l]) begin
                out_cos_next[l] = -$signed(sat);
            end else begin
                out_cos_next[l] = $signed(sat);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            for (int s = 0; s <= SqStages; s++) begin
                s_valid_reg[s] <= 1'b0;
            end
            for (int s = 0; s <= DvStages; s++) begin
                v_valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg    <= in_valid;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg    <= c_valid_reg;
            e_valid_reg    <= d_valid_reg;
            s_valid_reg[0] <= e_valid_reg;
            for (int s = 0; s < SqStages; s++) begin
                s_valid_reg[s+1] <= s_valid_reg[s];
            end
            v_valid_reg[0] <= s_valid_reg[SqStages];
            for (int s = 0; s < DvStages; s++) begin
                v_valid_reg[s+1] <= v_valid_reg[s];
            end
            out_valid_reg <= v_valid_reg[DvStages];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tag_reg <= in_tag;
            for (int c = 0; c < Axes; c++) begin
                a_vec_reg[0][c] <= VecW'(in_d[c]);
                a_vec_reg[1][c] <= VecW'(in_d[Axes+c]);
                a_vec_reg[2][c] <= -(VecW'(in_d[c]) + VecW'(in_d[Axes+c]));
            end

            b_tag_reg <= a_tag_reg;
            for (int l = 0; l < CosLanes; l++) begin
                for (int c = 0; c < Axes; c++) begin
                    b_neg_reg[l][c] <= a_vec_reg[l][c][VecW-1];
                    b_mag_reg[l][c] <= a_vec_reg[l][c][VecW-1] ? VecW'(-a_vec_reg[l][c])
                                                               : VecW'(a_vec_reg[l][c]);
                end
                b_or_reg[l] <= VecW'(a_vec_reg[l][0][VecW-1] ? -a_vec_reg[l][0]
                                                             : a_vec_reg[l][0])
                             | VecW'(a_vec_reg[l][1][VecW-1] ? -a_vec_reg[l][1]
                                                             : a_vec_reg[l][1])
                             | VecW'(a_vec_reg[l][2][VecW-1] ? -a_vec_reg[l][2]
                                                             : a_vec_reg[l][2]);
            end

            c_tag_reg <= b_tag_reg;
            for (int l = 0; l < CosLanes; l++) begin
                c_len_reg[l] <= c_len_next[l];
                for (int c = 0; c < Axes; c++) begin
                    c_mag_reg[l][c] <= b_mag_reg[l][c];
                    c_neg_reg[l][c] <= b_neg_reg[l][c];
                end
            end

            d_tag_reg <= c_tag_reg;
            for (int l = 0; l < CosLanes; l++) begin
                d_zero_reg[l] <= (c_len_reg[l] == '0);
                for (int c = 0; c < Axes; c++) begin
                    d_norm_reg[l][c] <= d_norm_next[l][c];
                    d_neg_reg[l][c]  <= c_neg_reg[l][c];
                end
            end

            e_tag_reg <= d_tag_reg;
            for (int l = 0; l < CosLanes; l++) begin
                e_zero_reg[l] <= d_zero_reg[l];
                for (int c = 0; c < Axes; c++) begin
                    e_sq_reg[l][c]   <= d_norm_reg[l][c] * d_norm_reg[l][c];
                    e_prod_reg[l][c] <= $signed({1'b0, d_norm_reg[l][c]}) * normal[c];
                    e_neg_reg[l][c]  <= d_neg_reg[l][c];
                end
            end

            s_tag_reg[0] <= e_tag_reg;
            for (int l = 0; l < CosLanes; l++) begin
                s_m_reg[0][l]    <= sum_m[l];
                s_rem_reg[0][l]  <= '0;
                s_res_reg[0][l]  <= '0;
                s_dot_reg[0][l]  <= sum_dot[l];
                s_zero_reg[0][l] <= e_zero_reg[l];
            end
            for (int s = 0; s < SqStages; s++) begin
                s_tag_reg[s+1] <= s_tag_reg[s];
                for (int l = 0; l < CosLanes; l++) begin
                    s_m_reg[s+1][l]    <= s_m_next[s][l];
                    s_rem_reg[s+1][l]  <= s_rem_next[s][l];
                    s_res_reg[s+1][l]  <= s_res_next[s][l];
                    s_dot_reg[s+1][l]  <= s_dot_reg[s][l];
                    s_zero_reg[s+1][l] <= s_zero_reg[s][l];
                end
            end

            v_tag_reg[0] <= s_tag_reg[SqStages];
            for (int l = 0; l < CosLanes; l++) begin
                v_rem_reg[0][l]  <= prep_rem[l];
                v_low_reg[0][l]  <= prep_low[l];
                v_q_reg[0][l]    <= '0;
                v_den_reg[0][l]  <= prep_den[l];
                v_neg_reg[0][l]  <= s_dot_reg[SqStages][l][DotW-1];
                v_zero_reg[0][l] <= s_zero_reg[SqStages][l];
            end
            for (int s = 0; s < DvStages; s++) begin
                v_tag_reg[s+1] <= v_tag_reg[s];
                for (int l = 0; l < CosLanes; l++) begin
                    v_rem_reg[s+1][l]  <= v_rem_next[s][l];
                    v_low_reg[s+1][l]  <= v_low_next[s][l];
                    v_q_reg[s+1][l]    <= v_q_next[s][l];
                    v_den_reg[s+1][l]  <= v_den_reg[s][l];
                    v_neg_reg[s+1][l]  <= v_neg_reg[s][l];
                    v_zero_reg[s+1][l] <= v_zero_reg[s][l];
                end
            end

            out_tag_reg <= v_tag_reg[DvStages];
            for (int l = 0; l < CosLanes; l++) begin
                out_cos_reg[l] <= out_cos_next[l];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_cos   = out_cos_reg;

endmodule

`default_nettype wire

/* rtl/water_orientation_cosines.sv */
// ----------------------------------------------------------------------------
// Water orientation cosines
// Per molecule: O-H1, O-H2 and dipole cosines against a surface normal, with
// minimum-image folding of the displacements.
//
//   port group   dir   handshake         word
//   s_*          in    s_valid/s_ready   water_in_t  (O, H1, H2, index, last)
//   m_*          out   m_valid/m_ready   water_out_t (index, 3 cosines, O z)
//   cfg_*        in    cfg_we            register index and data, no wait
//
// One word enters per cycle and one result leaves per cycle unless the output
// stalls. Stages take two divider/root steps each by default in the 34-step
// fold division, the 31-step square root and the 20-step rounding divide.
// The whole pipeline holds while m_valid is high and m_ready is low; s_ready
// is high whenever the output register is empty or being taken.
// Reset clears the valid bits and the registers (normal_z to one).
// ----------------------------------------------------------------------------
`default_nettype none

module water_orientation_cosines #(
    parameter int STEPS_PER_STAGE = wcos_pkg::StepsPerStageDefault
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wcos_pkg::water_in_t                s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output wcos_pkg::water_out_t               m_data,
    input  wire logic                          cfg_we,
    input  wire logic [wcos_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire logic [wcos_pkg::BoxW-1:0]     cfg_data
);
    import wcos_pkg::*;

    box_t  box_reg [Axes];
    cos_t  normal_reg [Axes];
    logic  no_z_wrap_reg;

    logic  en;
    logic  in_valid_reg;
    tag_t  in_tag_reg;
    diff_t diff_reg [FoldLanes];

    box_t  lane_len  [FoldLanes];
    logic  lane_wrap [FoldLanes];

    logic  fold_valid;
    tag_t  fold_tag;
    diff_t fold_d [FoldLanes];

    logic  cos_valid;
    tag_t  cos_tag;
    cos_t  cos_val [CosLanes];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < Axes; a++) begin
                box_reg[a] <= '0;
            end
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= CosW'(CosOneInt);
            no_z_wrap_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BOX_X:     box_reg[0]    <= cfg_data;
                REG_BOX_Y:     box_reg[1]    <= cfg_data;
                REG_BOX_Z:     box_reg[2]    <= cfg_data;
                REG_NORMAL_X:  normal_reg[0] <= cfg_data[CosW-1:0];
                REG_NORMAL_Y:  normal_reg[1] <= cfg_data[CosW-1:0];
                REG_NORMAL_Z:  normal_reg[2] <= cfg_data[CosW-1:0];
                REG_NO_Z_WRAP: no_z_wrap_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance everything unless a finished word is waiting
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        for (int l = 0; l < FoldLanes; l++) begin
            lane_len[l]  = box_reg[l % Axes];
            lane_wrap[l] = (box_reg[l % Axes] != '0)
                           && !((l % Axes == Axes - 1) && no_z_wrap_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_tag_reg.index  <= s_data.water_index;
            in_tag_reg.last   <= s_data.last_in_frame;
            in_tag_reg.height <= s_data.o_z;
            diff_reg[0] <= DiffW'(s_data.h1_x) - DiffW'(s_data.o_x);
            diff_reg[1] <= DiffW'(s_data.h1_y) - DiffW'(s_data.o_y);
            diff_reg[2] <= DiffW'(s_data.h1_z) - DiffW'(s_data.o_z);
            diff_reg[3] <= DiffW'(s_data.h2_x) - DiffW'(s_data.o_x);
            diff_reg[4] <= DiffW'(s_data.h2_y) - DiffW'(s_data.o_y);
            diff_reg[5] <= DiffW'(s_data.h2_z) - DiffW'(s_data.o_z);
        end
    end

    wcos_fold #(
        .STEPS_PER_STAGE(STEPS_PER_STAGE)
    ) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_tag    (in_tag_reg),
        .in_d      (diff_reg),
        .in_len    (lane_len),
        .in_wrap   (lane_wrap),
        .out_valid (fold_valid),
        .out_tag   (fold_tag),
        .out_d     (fold_d)
    );

    wcos_cos #(
        .STEPS_PER_STAGE(STEPS_PER_STAGE)
    ) u_cos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fold_valid),
        .in_tag    (fold_tag),
        .in_d      (fold_d),
        .normal    (normal_reg),
        .out_valid (cos_valid),
        .out_tag   (cos_tag),
        .out_cos   (cos_val)
    );

    assign m_valid = cos_valid;

    always_comb begin
        m_data.molecule_index = cos_tag.index;
        m_data.cos_oh1        = cos_val[0];
        m_data.cos_oh2        = cos_val[1];
        m_data.cos_dipole     = cos_val[2];
        m_data.oxygen_height  = cos_tag.height;
        m_data.frame_end      = cos_tag.last;
    end

endmodule

`default_nettype wire

/* tb/wcos_checker.sv */
// ----------------------------------------------------------------------------
// Water orientation cosines: result checker
// Watches both channels, predicts each molecule's cosines from the register
// settings it mirrors, and compares every result word with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module wcos_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wcos_pkg::water_in_t                s_data,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wcos_pkg::water_out_t               m_data,
    input  wire logic                          cfg_we,
    input  wire logic [wcos_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire logic [wcos_pkg::BoxW-1:0]     cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_seen
);
    import wcos_pkg::*;

    logic [30:0]        box_len [3];
    logic signed [15:0] normal [3];
    logic               z_fixed;

    water_out_t cosines_due [$];

    function automatic logic signed [35:0] min_image(input logic signed [35:0] d,
                                                     input logic [30:0] len);
        logic [35:0] mag;
        logic [35:0] q;
        logic [67:0] qlen;
        if (len == 0) return d;
        mag  = d < 0 ? -d : d;
        q    = (2 * {32'd0, mag} + len) / (2 * {37'd0, len});
        qlen = q * len;
        return d < 0 ? d + qlen[35:0] : d - qlen[35:0];
    endfunction

    function automatic logic [31:0] root_floor(input logic [63:0] m);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > m) bitv >>= 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m   = m - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic cos_t angle_cosine(input logic signed [35:0] v [3]);
        logic [35:0] a [3];
        logic [35:0] mx;
        logic [63:0] m, mag, c;
        logic signed [63:0] dot;
        logic [31:0] r;
        int nbits;
        mx = 0; m = 0; dot = 0; nbits = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = v[i] < 0 ? -v[i] : v[i];
            if (a[i] > mx) mx = a[i];
        end
        if (mx == 0) return '0;
        while (nbits < 36 && (mx >> nbits) != 0) nbits++;
        for (int i = 0; i < 3; i++) begin
            if (nbits > 30) a[i] = a[i] >> (nbits - 30);
            else a[i] = a[i] << (30 - nbits);
            m   += a[i] * a[i];
            dot += (v[i] < 0 ? -$signed({28'd0, a[i]}) : $signed({28'd0, a[i]}))
                   * 64'(normal[i]);
        end
        r   = root_floor(m);
        mag = dot < 0 ? -dot : dot;
        c   = (2 * mag + r) / (2 * 64'(r));
        if (c > CosOneInt) c = CosOneInt;
        return dot < 0 ? cos_t'(-c) : cos_t'(c);
    endfunction

    function automatic water_out_t predict_cosines(input water_in_t w);
        logic signed [35:0] o [3], h1 [3], h2 [3], v1 [3], v2 [3], dp [3];
        water_out_t r;
        o  = '{w.o_x, w.o_y, w.o_z};
        h1 = '{w.h1_x, w.h1_y, w.h1_z};
        h2 = '{w.h2_x, w.h2_y, w.h2_z};
        for (int i = 0; i < 3; i++) begin
            v1[i] = h1[i] - o[i];
            v2[i] = h2[i] - o[i];
            if (i < 2 || !z_fixed) begin
                v1[i] = min_image(v1[i], box_len[i]);
                v2[i] = min_image(v2[i], box_len[i]);
            end
        end
        for (int i = 0; i < 3; i++) dp[i] = -(v1[i] + v2[i]);
        r.molecule_index = w.water_index;
        r.cos_oh1        = angle_cosine(v1);
        r.cos_oh2        = angle_cosine(v2);
        r.cos_dipole     = angle_cosine(dp);
        r.oxygen_height  = w.o_z;
        r.frame_end      = w.last_in_frame;
        return r;
    endfunction

    always @(posedge aclk) begin
        water_out_t want;
        if (!aresetn) begin
            box_len = '{default: '0};
            normal  = '{16'sd0, 16'sd0, 16'sd16384};
            z_fixed = 1'b0;
            cosines_due.delete();
            fail_count   = 0;
            results_seen = 0;
            pending      = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (cosines_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word %h", $realtime, m_data);
                end else begin
                    want = cosines_due.pop_front();
                    if (want !== m_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch, expected %h got %h",
                                $realtime, want, m_data);
                    end
                end
            end
            // predict with the settings in force before this edge's write
            if (s_valid && s_ready) cosines_due = {cosines_due, predict_cosines(s_data)};
            pending = cosines_due.size();
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_BOX_X:     box_len[0] = cfg_data;
                    REG_BOX_Y:     box_len[1] = cfg_data;
                    REG_BOX_Z:     box_len[2] = cfg_data;
                    REG_NORMAL_X:  normal[0] = cfg_data[15:0];
                    REG_NORMAL_Y:  normal[1] = cfg_data[15:0];
                    REG_NORMAL_Z:  normal[2] = cfg_data[15:0];
                    REG_NO_Z_WRAP: z_fixed = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

`default_nettype wire

/* tb/tb_water_orientation_cosines.sv */
// ----------------------------------------------------------------------------
// Water orientation cosines: testbench top
// Writes several register settings, streams directed and random molecules
// with random gaps on both sides and one long output stall, then gives the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_water_orientation_cosines;
    import wcos_pkg::*;

    localparam int Latency    = 54;
    localparam int CycleLimit = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    water_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    water_out_t m_data;
    logic cfg_we = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [BoxW-1:0] cfg_data = '0;

    int fail_count, pending, results_seen;
    int cycles = 0;
    int molecules_sent = 0;
    bit hold_output = 1'b0;
    bit sink_busy = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    water_orientation_cosines DUT (.*);

    wcos_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** water_orientation_cosines: FAILED **");
            $finish;
        end
    end

    // receiver: random gaps before taking each word, or a long hold
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_output) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else begin
                gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 18);
                if (sink_busy) gap = 0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk iff (m_valid || hold_output));
                while (!(m_valid && m_ready) && !hold_output) @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [BoxW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [30:0] bx, by, bz,
                                 input logic [15:0] nx, ny, nz, input bit zfix);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_NORMAL_X, {15'd0, nx});
        write_reg(REG_NORMAL_Y, {15'd0, ny});
        write_reg(REG_NORMAL_Z, {15'd0, nz});
        write_reg(REG_NO_Z_WRAP, {30'd0, zfix});
        cfg_we <= 1'b0;
    endtask

    task automatic send_molecule(input water_in_t w, input bit no_gap);
        int gap;
        gap = (!no_gap && ($urandom & 3) != 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk iff s_ready);
        molecules_sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (Latency + 10) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            default: return $signed($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    // mostly water-like with H near O; sometimes H anywhere or very close to O; O anywhere
    function automatic water_in_t random_water();
        water_in_t w;
        int mode;
        mode = $urandom_range(0, 9);
        w.o_x = $urandom; w.o_y = $urandom; w.o_z = $urandom;
        if (mode < 7) begin
            w.h1_x = w.o_x + rand_coord(1); w.h1_y = w.o_y + rand_coord(1);
            w.h1_z = w.o_z + rand_coord(1);
            w.h2_x = w.o_x + rand_coord(1); w.h2_y = w.o_y + rand_coord(1);
            w.h2_z = w.o_z + rand_coord(1);
        end else if (mode < 9) begin
            w.h1_x = $urandom; w.h1_y = $urandom; w.h1_z = $urandom;
            w.h2_x = $urandom; w.h2_y = $urandom; w.h2_z = $urandom;
        end else begin
            w.h1_x = w.o_x + rand_coord(2); w.h1_y = w.o_y + rand_coord(2);
            w.h1_z = w.o_z + rand_coord(2);
            w.h2_x = w.o_x + rand_coord(2); w.h2_y = w.o_y + rand_coord(2);
            w.h2_z = w.o_z + rand_coord(2);
        end
        w.water_index   = 16'($urandom);
        w.last_in_frame = ($urandom_range(0, 15) == 0);
        return w;
    endfunction

    function automatic water_in_t make_water(input logic [31:0] ox, oy, oz,
                                             h1x, h1y, h1z, h2x, h2y, h2z,
                                             input logic [15:0] idx);
        water_in_t w;
        w = {ox, oy, oz, h1x, h1y, h1z, h2x, h2y, h2z, idx, idx[0]};
        return w;
    endfunction

    initial begin
        logic [15:0] nx, ny, nz;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings: no wrapping, normal along z
        send_molecule(make_water(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b1);
        send_molecule(make_water(0, 0, 0, 0, 0, 32'h0010_0000, 0, 0, 32'hfff0_0000, 16'hffff), 1'b0);
        send_molecule(make_water(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h5555), 1'b0);
        send_molecule(make_water(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'haaaa), 1'b0);
        send_molecule(make_water(0, 0, 5, 1, 0, 5, 0, 1, 6, 16'h0001), 1'b0);
        drain();

        // wrapping on, exact half-box displacements round away from zero
        load_settings(31'h0100_0000, 31'h7fff_ffff, 31'd1, 16'h2d41, 16'hd2bf, 16'h0000, 1'b0);
        send_molecule(make_water(0, 0, 0, 32'h0080_0000, 32'h3fff_ffff, 0,
                                 32'hff80_0000, 32'hc000_0000, 1, 16'd7), 1'b1);
        send_molecule(make_water(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 0, 0, 0, 16'd8), 1'b0);
        send_molecule(make_water(0, 0, 0, 32'h0100_0000, 0, 0, 32'h0200_0000, 0, 0, 16'd9), 1'b0);
        drain();
        // normal beyond one, negative full scale, slab z
        load_settings(31'h7fff_ffff, 31'h0000_0001, 31'h0300_0000, 16'h7fff, 16'h8000, 16'hc000,
                      1'b1);
        send_molecule(make_water(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0500_0000,
                                 32'hffff_0000, 0, 32'hfb00_0000, 16'd10), 1'b1);
        send_molecule(make_water(1, 2, 3, 3, 2, 1, 1, 1, 1, 16'd11), 1'b0);
        drain();
        load_settings(31'd0, 31'd0, 31'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_molecule(make_water(0, 0, 0, 1, 1, 1, 2, 2, 2, 16'd12), 1'b0);
        drain();

        // random phases, each with its own settings
        for (int ph = 0; ph < 8; ph++) begin
            nx = 16'($urandom_range(0, 32768) - 16384);
            ny = 16'($urandom_range(0, 32768) - 16384);
            nz = (ph == 7) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
            load_settings(($urandom & 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h0400_0000)),
                          ($urandom & 3) ? 31'($urandom_range(1, 32'h0800_0000)) : 31'd0,
                          ($urandom & 3) ? 31'($urandom) : 31'd0,
                          nx, ny, nz, ph[0]);
            for (int i = 0; i < 250; i++) begin
                if (ph == 3 && i == 20) begin
                    fork
                        begin
                            hold_output = 1'b1;
                            repeat (400) @(posedge aclk);
                            hold_output = 1'b0;
                        end
                    join_none
                end
                sink_busy = (ph == 5);
                send_molecule(random_water(), ph == 5);
            end
            sink_busy = 1'b0;
            drain();
        end

        $display("%0d molecules sent, %0d results checked over 12 register settings",
                 molecules_sent, results_seen);
        $display("included zero vectors, coordinate extremes, half-box ties, a long output stall");
        if (fail_count == 0)
            $display("** water_orientation_cosines: PASSED **");
        else
            $display("** water_orientation_cosines: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
